FILE: rtl/core/srt_pkg.sv
// Shared types and codes for the sorted record table.
package srt_pkg;

    localparam logic [9:0] GRADE_MAX = 10'd1000;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [1:0] CMP_UND = 2'd0;
    localparam logic [1:0] CMP_LT  = 2'd1;
    localparam logic [1:0] CMP_EQ  = 2'd2;
    localparam logic [1:0] CMP_GT  = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_COPY  = 8'b0000_0010,
        S_MAPRD = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_SHRD  = 8'b0001_0000,
        S_SHWR  = 8'b0010_0000,
        S_PLACE = 8'b0100_0000,
        S_RDOUT = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic       clr;
        logic       en;
        logic [7:0] sur_a;
        logic [7:0] sur_b;
        logic [7:0] giv_a;
        logic [7:0] giv_b;
    } t_cmp_req;

endpackage

FILE: rtl/core/srt_key_cmp.sv
// Byte-serial compare of a stored key against the new key, surname first.
module srt_key_cmp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srt_pkg::t_cmp_req i_req,
    output logic              o_greater
);
    import srt_pkg::*;

    logic [1:0] r_sur, n_sur;
    logic [1:0] r_giv, n_giv;

    function automatic logic [1:0] step(input logic [1:0] s, input logic [7:0] a,
                                        input logic [7:0] b);
        logic [1:0] r;
        r = s;
        if (s == CMP_UND) begin
            if (a != b) r = (a > b) ? CMP_GT : CMP_LT;
            else if (a == 8'd0) r = CMP_EQ;
        end
        return r;
    endfunction

    always_comb begin
        n_sur = r_sur;
        n_giv = r_giv;
        if (i_req.clr) begin
            n_sur = CMP_UND;
            n_giv = CMP_UND;
        end else if (i_req.en) begin
            n_sur = step(r_sur, i_req.sur_a, i_req.sur_b);
            n_giv = step(r_giv, i_req.giv_a, i_req.giv_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sur <= CMP_UND;
            r_giv <= CMP_UND;
        end else begin
            r_sur <= n_sur;
            r_giv <= n_giv;
        end
    end

    // an undecided name at the end of the sweep counts as equal
    assign o_greater = (r_sur == CMP_GT) || ((r_sur != CMP_LT) && (r_giv == CMP_GT));

endmodule

FILE: rtl/core/sorted_record_table_top.sv
// Sorted record table: staging, name store, order map and insertion sequencer.
//
// A load item that is not marked last keeps busy low. So does a read whose index is out
// of range, and a last load item that finds the table full; their result is registered
// and appears in the next cycle. Any other last load item commits the record: the staged
// names are copied into a free slot. The stored entries are then compared in order-map
// order against the new key by byte-serial compare, up to and including the first entry
// found greater, or until the end of the table is reached. Each entry from there on is
// moved down the order map, read then written, and the record is then placed. A read
// item emits NAME_LEN results, one per cycle. The single compare unit walks one byte of
// each name per cycle through the name store.
// Results appear for one cycle with o_strobe and cannot be held off.
module sorted_record_table_top #(
    parameter int CAPACITY = 32,
    parameter int NAME_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_action,
    input  logic [7:0] i_surname_char,
    input  logic [7:0] i_given_char,
    input  logic [9:0] i_grade,
    input  logic [4:0] i_entry_index,
    input  logic       i_last,
    output logic       o_strobe,
    output logic [1:0] o_status,
    output logic [7:0] o_out_surname_char,
    output logic [7:0] o_out_given_char,
    output logic [9:0] o_out_grade,
    output logic [5:0] o_entry_count,
    output logic       o_final_res
);
    import srt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY);
    localparam int KW = $clog2(NAME_LEN);
    localparam int LW = $clog2(NAME_LEN + 1);
    localparam int NAW = SW + KW;
    localparam int NDEPTH = CAPACITY * (1 << KW);
    localparam int XW = (SW > 5) ? SW : 5;

    logic [7:0]    mem_sur [NDEPTH];
    logic [7:0]    mem_giv [NDEPTH];
    logic [7:0]    stg_sur [1 << KW];
    logic [7:0]    stg_giv [1 << KW];
    logic [SW-1:0] mem_map [CAPACITY];
    logic [9:0]    mem_grade [CAPACITY];

    t_state      r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_lp, n_lp;
    logic [LW-1:0] r_k, n_k;
    logic [KW-1:0] r_kd, n_kd;
    logic          r_dv, n_dv;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_e, n_e;
    logic          r_sur_end, n_sur_end;
    logic          r_giv_end, n_giv_end;

    logic [SW-1:0] r_map_q;
    logic [7:0]    r_sur_qa, r_sur_qb, r_giv_qa, r_giv_qb;
    logic [7:0]    r_stg_sur_q, r_stg_giv_q;
    logic [9:0]    r_grade_q;

    logic          n_strobe, n_final;
    logic [1:0]    n_status;
    logic [7:0]    n_osur, n_ogiv;
    logic [9:0]    n_ograde;
    logic [5:0]    n_ocount;

    logic          accept;
    logic          sweep_go, sweep_done;
    logic [SW-1:0] new_slot;
    logic [XW-1:0] idx_x;
    logic          idx_bad;
    logic [9:0]    grade_sat;
    logic [7:0]    cp_sur, cp_giv, wr_sur, wr_giv;
    logic [CW-1:0] e_prev;

    logic          stg_we, name_we, map_we, map_re, grade_we;
    logic [SW-1:0] map_wa, map_ra, map_wd;
    logic [NAW-1:0] addr_a, addr_b, name_wa;

    t_cmp_req      cmp_req;
    logic          cmp_greater;

    srt_key_cmp u_cmp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (cmp_req),
        .o_greater (cmp_greater)
    );

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign sweep_go   = (r_k < LW'(NAME_LEN));
    assign sweep_done = !sweep_go && !r_dv;
    assign new_slot   = r_cnt[SW-1:0];
    assign idx_x      = XW'(i_entry_index);
    assign idx_bad    = ({{CW{1'b0}}, i_entry_index} >= {5'd0, r_cnt});
    assign grade_sat  = (i_grade > GRADE_MAX) ? GRADE_MAX : i_grade;
    assign e_prev     = r_e - 1'b1;

    // staged bytes past the fill point read as zero
    assign cp_sur = (LW'(r_kd) < r_lp) ? r_stg_sur_q : 8'd0;
    assign cp_giv = (LW'(r_kd) < r_lp) ? r_stg_giv_q : 8'd0;
    assign wr_sur = r_sur_end ? 8'd0 : cp_sur;
    assign wr_giv = r_giv_end ? 8'd0 : cp_giv;

    assign addr_a  = {r_map_q, r_k[KW-1:0]};
    assign addr_b  = {new_slot, r_k[KW-1:0]};
    assign name_wa = {new_slot, r_kd};

    assign stg_we   = accept && (i_action == ACT_LOAD) && (r_lp < LW'(NAME_LEN));
    assign grade_we = accept && (i_action == ACT_LOAD) && i_last
                      && (r_cnt != CW'(CAPACITY));
    assign name_we  = (r_state == S_COPY) && r_dv;

    assign cmp_req.clr   = (r_state == S_MAPRD);
    assign cmp_req.en    = (r_state == S_CMP) && r_dv;
    assign cmp_req.sur_a = r_sur_qa;
    assign cmp_req.sur_b = r_sur_qb;
    assign cmp_req.giv_a = r_giv_qa;
    assign cmp_req.giv_b = r_giv_qb;

    always_comb begin
        map_ra = r_pos[SW-1:0];
        map_re = 1'b0;
        map_we = 1'b0;
        map_wa = r_e[SW-1:0];
        map_wd = r_map_q;
        unique case (r_state)
            S_IDLE: begin
                map_ra = idx_x[SW-1:0];
                map_re = 1'b1;
            end
            S_MAPRD: map_re = 1'b1;
            S_SHRD: begin
                map_ra = e_prev[SW-1:0];
                map_re = 1'b1;
            end
            S_SHWR: map_we = 1'b1;
            S_PLACE: begin
                map_we = 1'b1;
                map_wa = r_pos[SW-1:0];
                map_wd = new_slot;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_lp      = r_lp;
        n_k       = r_k;
        n_kd      = r_kd;
        n_dv      = r_dv;
        n_pos     = r_pos;
        n_e       = r_e;
        n_sur_end = r_sur_end;
        n_giv_end = r_giv_end;
        n_strobe  = 1'b0;
        n_status  = ST_ADDED;
        n_osur    = 8'd0;
        n_ogiv    = 8'd0;
        n_ograde  = 10'd0;
        n_ocount  = 6'(r_cnt);
        n_final   = 1'b1;
        if (r_state == S_COPY || r_state == S_CMP || r_state == S_RDOUT) begin
            n_k  = sweep_go ? r_k + 1'b1 : r_k;
            n_dv = sweep_go;
            n_kd = r_k[KW-1:0];
        end
        unique case (r_state)
            S_IDLE: begin
                n_k  = '0;
                n_dv = 1'b0;
                if (accept && i_action == ACT_READ) begin
                    if (idx_bad) begin
                        n_strobe = 1'b1;
                        n_status = ST_RANGE;
                    end else begin
                        n_state = S_RDOUT;
                    end
                end else if (accept) begin
                    if (stg_we) n_lp = r_lp + 1'b1;
                    if (i_last) begin
                        if (r_cnt == CW'(CAPACITY)) begin
                            n_strobe = 1'b1;
                            n_status = ST_FULL;
                            n_lp     = '0;
                        end else begin
                            n_state   = S_COPY;
                            n_sur_end = 1'b0;
                            n_giv_end = 1'b0;
                        end
                    end
                end
            end
            S_COPY: begin
                if (r_dv) begin
                    n_sur_end = r_sur_end || (cp_sur == 8'd0);
                    n_giv_end = r_giv_end || (cp_giv == 8'd0);
                end
                if (sweep_done) begin
                    n_state = S_MAPRD;
                    n_pos   = '0;
                end
            end
            S_MAPRD: begin
                n_k  = '0;
                n_dv = 1'b0;
                if (r_pos == r_cnt) begin
                    n_e     = r_cnt;
                    n_state = S_SHRD;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (sweep_done) begin
                    if (cmp_greater) begin
                        n_e     = r_cnt;
                        n_state = S_SHRD;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_state = S_MAPRD;
                    end
                end
            end
            S_SHRD: n_state = (r_e == r_pos) ? S_PLACE : S_SHWR;
            S_SHWR: begin
                n_e     = e_prev;
                n_state = S_SHRD;
            end
            S_PLACE: begin
                n_cnt    = r_cnt + 1'b1;
                n_lp     = '0;
                n_strobe = 1'b1;
                n_status = ST_ADDED;
                n_ocount = 6'(r_cnt + 1'b1);
                n_state  = S_IDLE;
            end
            S_RDOUT: begin
                if (r_dv) begin
                    n_strobe = 1'b1;
                    n_status = ST_READ;
                    n_osur   = r_sur_qa;
                    n_ogiv   = r_giv_qa;
                    n_ograde = r_grade_q;
                    n_final  = (r_kd == KW'(NAME_LEN - 1));
                end
                if (sweep_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_lp     <= '0;
            r_k      <= '0;
            r_dv     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_lp     <= n_lp;
            r_k      <= n_k;
            r_dv     <= n_dv;
            o_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kd               <= n_kd;
        r_pos              <= n_pos;
        r_e                <= n_e;
        r_sur_end          <= n_sur_end;
        r_giv_end          <= n_giv_end;
        o_status           <= n_status;
        o_out_surname_char <= n_osur;
        o_out_given_char   <= n_ogiv;
        o_out_grade        <= n_ograde;
        o_entry_count      <= n_ocount;
        o_final_res        <= n_final;
    end

    always_ff @(posedge i_clk) begin
        if (stg_we) begin
            stg_sur[r_lp[KW-1:0]] <= i_surname_char;
            stg_giv[r_lp[KW-1:0]] <= i_given_char;
        end
        r_stg_sur_q <= stg_sur[r_k[KW-1:0]];
        r_stg_giv_q <= stg_giv[r_k[KW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (name_we) begin
            mem_sur[name_wa] <= wr_sur;
            mem_giv[name_wa] <= wr_giv;
        end
        r_sur_qa <= mem_sur[addr_a];
        r_giv_qa <= mem_giv[addr_a];
        r_sur_qb <= mem_sur[addr_b];
        r_giv_qb <= mem_giv[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) mem_map[map_wa] <= map_wd;
        if (map_re) r_map_q <= mem_map[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (grade_we) mem_grade[new_slot] <= grade_sat;
        r_grade_q <= mem_grade[r_map_q];
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("record count above capacity");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP || r_state == S_SHRD) |-> (r_pos <= r_cnt))
        else $error("insert position beyond count");

    a_place_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE) |=> (o_strobe && o_status == ST_ADDED && o_final_res))
        else $error("placement without added result");

    a_mid_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_final_res) |-> (o_status == ST_READ))
        else $error("non-final result outside read-out");

endmodule
